// ===== hdl/pdcc_pkg.sv =====
// Shared types and constants for the pair distance correlation counter.
package pdcc_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;

  localparam int RAD_W   = 17;
  localparam int RATIO_W = 16;
  localparam int CNT_W   = 19;
  localparam int RNEXT_W = 25;
  localparam int SQ_W    = 34;
  localparam int NCNT_W  = 17;

  localparam logic [CNT_W-1:0]   COUNT_SAT      = 19'h7FFFF;
  localparam logic [RAD_W-1:0]   MIN_RADIUS_RST = 17'd1;
  localparam logic [RAD_W-1:0]   MAX_RADIUS_RST = 17'd65536;
  localparam logic [RATIO_W-1:0] RATIO_RST      = 16'd512;

  // register interface
  localparam int APB_AW = 4;
  localparam logic [1:0] REG_MIN_RADIUS   = 2'd0;
  localparam logic [1:0] REG_MAX_RADIUS   = 2'd1;
  localparam logic [1:0] REG_RADIUS_RATIO = 2'd2;

  // command queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [CNT_W-1:0] pairs_within;
    logic [CNT_W-1:0] pair_total;
    logic             store_overflow;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CLEAR,
    OP_RUN
  } op_t;

  typedef struct packed {
    op_t    op;
    point_t pt;
  } cmd_t;

  typedef struct packed {
    logic [RAD_W-1:0]   min_radius;
    logic [RAD_W-1:0]   max_radius;
    logic [RATIO_W-1:0] radius_ratio;
  } cfg_t;

endpackage

// ===== hdl/pair_distance_correlation_count_top.sv =====
// Top level of the pair distance correlation counter with its register port.
// Load and clear words: one per cycle while the back end is idle, through a four-word command queue.
// Run word with n stored points: all n(n-1)/2 pairs per radius (one pair per
// cycle through the distance pipeline, fed by the store's two read ports),
// no pairs below two points; up to MAX_RADII results per run.
// Synchronous rst empties the queue, zeroes point count and overflow flag, drops
// any pending result and restores register defaults; store contents are kept.
module pair_distance_correlation_count_top #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_RADII  = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pdcc_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pdcc_pkg::out_word_t            out_word,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pdcc_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pdcc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  cfg_t          cfg;
  logic          cfg_we;
  logic          cmd_valid;
  cmd_t          cmd;
  logic          cmd_take;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  point_t        st_wpoint;
  logic [AW-1:0] st_raddr_a;
  logic [AW-1:0] st_raddr_b;
  point_t        st_rpoint_a;
  point_t        st_rpoint_b;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_radius   <= MIN_RADIUS_RST;
      cfg.max_radius   <= MAX_RADIUS_RST;
      cfg.radius_ratio <= RATIO_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_MIN_RADIUS:   cfg.min_radius   <= pwdata[RAD_W-1:0];
        REG_MAX_RADIUS:   cfg.max_radius   <= pwdata[RAD_W-1:0];
        REG_RADIUS_RATIO: cfg.radius_ratio <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_RADIUS:   prdata = 32'(cfg.min_radius);
      REG_MAX_RADIUS:   prdata = 32'(cfg.max_radius);
      REG_RADIUS_RATIO: prdata = 32'(cfg.radius_ratio);
      default:          prdata = '0;
    endcase
  end

  pdcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  pdcc_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk      (clk),
    .we       (st_we),
    .waddr    (st_waddr),
    .wpoint   (st_wpoint),
    .raddr_a  (st_raddr_a),
    .raddr_b  (st_raddr_b),
    .rpoint_a (st_rpoint_a),
    .rpoint_b (st_rpoint_b)
  );

  pdcc_back #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_RADII  (MAX_RADII)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .cfg         (cfg),
    .st_we       (st_we),
    .st_waddr    (st_waddr),
    .st_wpoint   (st_wpoint),
    .st_raddr_a  (st_raddr_a),
    .st_raddr_b  (st_raddr_b),
    .st_rpoint_a (st_rpoint_a),
    .st_rpoint_b (st_rpoint_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

// ===== hdl/pdcc_store.sv =====
// Point store: one write port, two registered read ports.
module pdcc_store #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MAX_POINTS)-1:0] waddr,
  input  pdcc_pkg::point_t              wpoint,
  input  logic [$clog2(MAX_POINTS)-1:0] raddr_a,
  input  logic [$clog2(MAX_POINTS)-1:0] raddr_b,
  output pdcc_pkg::point_t              rpoint_a,
  output pdcc_pkg::point_t              rpoint_b
);
  import pdcc_pkg::*;

  point_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wpoint;
    end
    rpoint_a <= mem[raddr_a];
    rpoint_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/pdcc_front.sv =====
// Front end: accepts input words, classifies the action, queues commands.
module pdcc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pdcc_pkg::in_word_t in_word,
  output logic               cmd_valid,
  output pdcc_pkg::cmd_t     cmd,
  input  logic               cmd_take
);
  import pdcc_pkg::*;

  cmd_t            q [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_CW-1:0] q_count;
  cmd_t            dec;
  logic            keep;
  logic            push;
  logic            pop;

  always_comb begin
    dec.pt.x = in_word.point_x;
    dec.pt.y = in_word.point_y;
    dec.op   = OP_LOAD;
    keep     = 1'b1;
    case (in_word.action)
      ACT_LOAD:  dec.op = OP_LOAD;
      ACT_CLEAR: dec.op = OP_CLEAR;
      ACT_RUN:   dec.op = OP_RUN;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall  = (q_count == Q_CW'(Q_DEPTH));
  assign cmd_valid = (q_count != '0);
  assign cmd       = q[rptr];
  assign push      = in_valid && !in_stall && keep;
  assign pop       = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + Q_AW'(1);
      end
      if (push && !pop) begin
        q_count <= q_count + Q_CW'(1);
      end else if (pop && !push) begin
        q_count <= q_count - Q_CW'(1);
      end
    end
  end

endmodule

// ===== hdl/pdcc_back.sv =====
// Back end: point loads, store clear and the radius sweep over all point pairs.
module pdcc_back #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_RADII  = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  pdcc_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  input  pdcc_pkg::cfg_t                cfg,
  output logic                          st_we,
  output logic [$clog2(MAX_POINTS)-1:0] st_waddr,
  output pdcc_pkg::point_t              st_wpoint,
  output logic [$clog2(MAX_POINTS)-1:0] st_raddr_a,
  output logic [$clog2(MAX_POINTS)-1:0] st_raddr_b,
  input  pdcc_pkg::point_t              st_rpoint_a,
  input  pdcc_pkg::point_t              st_rpoint_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pdcc_pkg::out_word_t           out_word
);
  import pdcc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int KW = $clog2(MAX_RADII + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_WALK  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_STEP  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t               state;
  logic [NW-1:0]        count;
  logic                 ovf;
  logic [RNEXT_W-1:0]   r;
  logic [RNEXT_W-1:0]   r_nxt;
  logic [SQ_W-1:0]      r2;
  logic [KW-1:0]        k;
  logic [SQ_W-1:0]      tot_prod;
  logic [CNT_W-1:0]     pair_total;
  logic [AW-1:0]        a;
  logic [AW-1:0]        b;
  logic                 v1, v2, v3, v4;
  logic signed [16:0]   dx, dy;
  logic [31:0]          sqx, sqy;
  logic                 hit;
  logic [CNT_W-1:0]     cnt;

  logic                 load_ok;
  logic [SQ_W-1:0]      tot_mul;
  logic [SQ_W-2:0]      tot_half;
  logic [CNT_W-1:0]     tot_sat;
  logic [SQ_W-1:0]      rsq;
  logic [32:0]          step_prod;
  logic signed [33:0]   px, py;
  logic [32:0]          d2;
  logic                 last_res;
  logic                 emit_ok;

  assign load_ok   = (count < NW'(MAX_POINTS));
  assign tot_mul   = NCNT_W'(count) * NCNT_W'(count - NW'(1));
  assign tot_half  = tot_prod[SQ_W-1:1];
  assign tot_sat   = (tot_half > (SQ_W-1)'(COUNT_SAT)) ? COUNT_SAT : tot_half[CNT_W-1:0];
  assign rsq       = r[RAD_W-1:0] * r[RAD_W-1:0];
  assign step_prod = r[RAD_W-1:0] * cfg.radius_ratio;
  assign px        = dx * dx;
  assign py        = dy * dy;
  assign d2        = {1'b0, sqx} + {1'b0, sqy};
  assign last_res  = (k == KW'(MAX_RADII - 1)) || (r_nxt > RNEXT_W'(cfg.max_radius));
  assign emit_ok   = !out_valid || !out_stall;

  assign cmd_take   = (state == S_IDLE);
  assign st_we      = (state == S_IDLE) && cmd_valid && (cmd.op == OP_LOAD) && load_ok;
  assign st_waddr   = count[AW-1:0];
  assign st_wpoint  = cmd.pt;
  assign st_raddr_a = a;
  assign st_raddr_b = b;

  // distance pipeline: read, difference, square, sum and compare
  always_ff @(posedge clk) begin
    dx  <= {st_rpoint_a.x[15], st_rpoint_a.x} - {st_rpoint_b.x[15], st_rpoint_b.x};
    dy  <= {st_rpoint_a.y[15], st_rpoint_a.y} - {st_rpoint_b.y[15], st_rpoint_b.y};
    sqx <= px[31:0];
    sqy <= py[31:0];
    hit <= ({1'b0, d2} <= r2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= (state == S_WALK);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (v4 && hit && (cnt != COUNT_SAT)) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_LOAD: begin
                if (load_ok) begin
                  count <= count + NW'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              OP_CLEAR: begin
                count <= '0;
                ovf   <= 1'b0;
              end
              OP_RUN: begin
                r        <= RNEXT_W'(cfg.min_radius);
                k        <= '0;
                tot_prod <= tot_mul;
                state    <= S_CHECK;
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          pair_total <= tot_sat;
          r2         <= rsq;
          a          <= '0;
          b          <= AW'(1);
          cnt        <= '0;
          if (r > RNEXT_W'(cfg.max_radius)) begin
            state <= S_IDLE;
          end else if (count < NW'(2)) begin
            state <= S_STEP;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (NW'(b) == count - NW'(1)) begin
            if (NW'(a) == count - NW'(2)) begin
              state <= S_DRAIN;
            end else begin
              a <= a + AW'(1);
              b <= a + AW'(2);
            end
          end else begin
            b <= b + AW'(1);
          end
        end
        S_DRAIN: begin
          if (!(v1 || v2 || v3 || v4)) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          r_nxt <= step_prod[32:8];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid               <= 1'b1;
            out_word.radius         <= r[RAD_W-1:0];
            out_word.pairs_within   <= cnt;
            out_word.pair_total     <= pair_total;
            out_word.store_overflow <= ovf;
            out_word.last           <= last_res;
            r                       <= r_nxt;
            k                       <= k + KW'(1);
            state                   <= last_res ? S_IDLE : S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/pdcc_check.sv =====
// Port-level assertions for the correlation counter, bound to the top level.
module pdcc_check (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input pdcc_pkg::out_word_t out_word
);
  import pdcc_pkg::*;

  logic             prev_open;
  logic [CNT_W-1:0] prev_total;
  logic             prev_ovf;

  // remembers the last word taken and whether its sweep is still open
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_open <= 1'b0;
    end else if (out_valid && !out_stall) begin
      prev_open  <= !out_word.last;
      prev_total <= out_word.pair_total;
      prev_ovf   <= out_word.store_overflow;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  a_within_le_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.pairs_within <= out_word.pair_total))
    else $error("pairs_within exceeds pair_total");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed");

  a_sweep_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && prev_open) |->
      ((out_word.pair_total == prev_total) && (out_word.store_overflow == prev_ovf)))
    else $error("pair total or overflow changed within a sweep");

endmodule

bind pair_distance_correlation_count_top pdcc_check u_check (.*);
